// File: src/swept_sphere_collision_unit_defines.svh
// Assertion macros for the swept sphere collision unit
`ifndef SWEPT_SPHERE_COLLISION_UNIT_DEFINES_SVH
`define SWEPT_SPHERE_COLLISION_UNIT_DEFINES_SVH

// implication checked on every clock edge outside reset
`define SSC_ASSERT_NOW(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("ssc assertion failed");

// consequent checked a fixed number of cycles after the antecedent
`define SSC_ASSERT_LATER(lbl, ante, dly, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> ##dly (cons)) \
      else $error("ssc assertion failed");

`endif

// File: src/ssc_pkg.sv
// Shared constants for the swept sphere collision unit
`timescale 1ns / 1ps
package ssc_pkg;
   localparam int COORD_WIDTH_DEF = 32;
   localparam int PIPE_DEPTH      = 8;
endpackage

// File: src/ssc_mul.sv
// Two-stage unsigned multiplier built from four half-width partial products
`timescale 1ns / 1ps
module ssc_mul
   import ssc_pkg::*;
#(
   parameter int AW = 33,
   parameter int BW = 33
) (
   input  logic               clock,
   input  logic [AW-1:0]      a,
   input  logic [BW-1:0]      b,
   output logic [AW+BW-1:0]   p
);
   localparam int HA = (AW + 1) / 2;
   localparam int HB = (BW + 1) / 2;
   localparam int UA = AW - HA;
   localparam int UB = BW - HB;

   logic [HA+HB-1:0] pp_ll_ff;
   logic [HA+UB-1:0] pp_lh_ff;
   logic [UA+HB-1:0] pp_hl_ff;
   logic [UA+UB-1:0] pp_hh_ff;
   logic [AW+BW-1:0] p_in;
   logic [AW+BW-1:0] p_ff;

   always_ff @(posedge clock) begin
      pp_ll_ff <= a[HA-1:0] * b[HB-1:0];
      pp_lh_ff <= a[HA-1:0] * b[BW-1:HB];
      pp_hl_ff <= a[AW-1:HA] * b[HB-1:0];
      pp_hh_ff <= a[AW-1:HA] * b[BW-1:HB];
      p_ff     <= p_in;
   end

   always_comb begin
      p_in = (AW+BW)'(pp_ll_ff)
           + ((AW+BW)'(pp_lh_ff) << HB)
           + ((AW+BW)'(pp_hl_ff) << HA)
           + ((AW+BW)'(pp_hh_ff) << (HA + HB));
   end

   assign p = p_ff;
endmodule

// File: src/swept_sphere_collision_unit.sv
// Top level of the swept sphere collision unit
`timescale 1ns / 1ps
// Swept sphere versus sphere hit test. One request is taken every clock cycle
// (busy is always low). Its hit flag is driven on rsp_hit with rsp_valid for one
// cycle, once the request has passed the vld_ff shift register and the
// exact-arithmetic chain; the receiver cannot stall. The chain runs through
// coordinate differences, registered products, sums, the registered squaring of
// the cross product, the cross product sum and the final compare. All
// arithmetic is exact, with no rounding.
module swept_sphere_collision_unit
   import ssc_pkg::*;
#(
   parameter int COORD_WIDTH = COORD_WIDTH_DEF
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   output logic                   busy,
   input  logic [COORD_WIDTH-1:0] req_prev_x,
   input  logic [COORD_WIDTH-1:0] req_prev_y,
   input  logic [COORD_WIDTH-1:0] req_prev_z,
   input  logic [COORD_WIDTH-1:0] req_now_x,
   input  logic [COORD_WIDTH-1:0] req_now_y,
   input  logic [COORD_WIDTH-1:0] req_now_z,
   input  logic [COORD_WIDTH-2:0] req_mover_radius,
   input  logic [COORD_WIDTH-1:0] req_target_x,
   input  logic [COORD_WIDTH-1:0] req_target_y,
   input  logic [COORD_WIDTH-1:0] req_target_z,
   input  logic [COORD_WIDTH-2:0] req_target_radius,
   output logic                   rsp_valid,
   output logic                   rsp_hit
);
   localparam int W  = COORD_WIDTH;
   localparam int DW = W + 1;
   localparam int PW = 2 * DW;
   localparam int SW = PW + 2;
   localparam int CW = PW + 1;
   localparam int RW = 2 * W;
   localparam int LW = RW + SW;
   localparam int QW = 2 * CW + 2;

   logic [W-1:0] pv [3];
   logic [W-1:0] nw [3];
   logic [W-1:0] tg [3];

   logic [PIPE_DEPTH-1:0] vld_ff;

   logic [DW-1:0] ab_mag_ff [3];
   logic [DW-1:0] ap_mag_ff [3];
   logic [DW-1:0] bp_mag_ff [3];
   logic [2:0]    ab_neg_ff, ap_neg_ff;
   logic [2:0]    ab_neg2_ff, ap_neg2_ff, ab_neg3_ff, ap_neg3_ff;
   logic [W-1:0]  rsum_ff;

   logic [DW-1:0] ab_mag_in [3];
   logic [DW-1:0] ap_mag_in [3];
   logic [DW-1:0] bp_mag_in [3];
   logic [2:0]    ab_neg_in, ap_neg_in;

   logic [PW-1:0] sq_ab [3];
   logic [PW-1:0] sq_ap [3];
   logic [PW-1:0] sq_bp [3];
   logic [PW-1:0] dot_p [3];
   logic [PW-1:0] cr    [6];
   logic [RW-1:0] r2;

   logic [SW-1:0] len2_ff, pos_ff, negs_ff, dap_ff, dbp_ff;
   logic [SW-1:0] len2_in, pos_in, negs_in, dap_in, dbp_in;
   logic [CW-1:0] cm_ff [3];
   logic [CW-1:0] cm_in [3];
   logic [RW-1:0] r2d_ff;

   logic [2*CW-1:0] sq_c [3];
   logic [LW-1:0]   rl;

   logic [3:0] flg5_ff, flg6_ff, flg7_ff;
   logic [QW-1:0] csum_ff;
   logic [LW-1:0] rl7_ff;
   logic          hit_in, hit_ff;

   assign pv[0] = req_prev_x;   assign pv[1] = req_prev_y;   assign pv[2] = req_prev_z;
   assign nw[0] = req_now_x;    assign nw[1] = req_now_y;    assign nw[2] = req_now_z;
   assign tg[0] = req_target_x; assign tg[1] = req_target_y; assign tg[2] = req_target_z;

   assign busy = 1'b0;

   always_comb begin
      logic signed [DW-1:0] d_ab, d_ap, d_bp;
      for (int i = 0; i < 3; i++) begin
         d_ab = $signed({nw[i][W-1], nw[i]}) - $signed({pv[i][W-1], pv[i]});
         d_ap = $signed({tg[i][W-1], tg[i]}) - $signed({pv[i][W-1], pv[i]});
         d_bp = $signed({tg[i][W-1], tg[i]}) - $signed({nw[i][W-1], nw[i]});
         ab_neg_in[i] = d_ab[DW-1];
         ap_neg_in[i] = d_ap[DW-1];
         ab_mag_in[i] = d_ab[DW-1] ? DW'(-d_ab) : DW'(d_ab);
         ap_mag_in[i] = d_ap[DW-1] ? DW'(-d_ap) : DW'(d_ap);
         bp_mag_in[i] = d_bp[DW-1] ? DW'(-d_bp) : DW'(d_bp);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= {vld_ff[PIPE_DEPTH-2:0], start & ~busy};
      end
   end

   always_ff @(posedge clock) begin
      ab_mag_ff  <= ab_mag_in;
      ap_mag_ff  <= ap_mag_in;
      bp_mag_ff  <= bp_mag_in;
      ab_neg_ff  <= ab_neg_in;
      ap_neg_ff  <= ap_neg_in;
      rsum_ff    <= W'(req_mover_radius) + W'(req_target_radius);
      ab_neg2_ff <= ab_neg_ff;
      ap_neg2_ff <= ap_neg_ff;
      ab_neg3_ff <= ab_neg2_ff;
      ap_neg3_ff <= ap_neg2_ff;
   end

   for (genvar g = 0; g < 3; g++) begin : g_axis
      ssc_mul #(.AW(DW), .BW(DW)) u_sq_ab (.clock, .a(ab_mag_ff[g]), .b(ab_mag_ff[g]),
                                           .p(sq_ab[g]));
      ssc_mul #(.AW(DW), .BW(DW)) u_sq_ap (.clock, .a(ap_mag_ff[g]), .b(ap_mag_ff[g]),
                                           .p(sq_ap[g]));
      ssc_mul #(.AW(DW), .BW(DW)) u_sq_bp (.clock, .a(bp_mag_ff[g]), .b(bp_mag_ff[g]),
                                           .p(sq_bp[g]));
      ssc_mul #(.AW(DW), .BW(DW)) u_dot   (.clock, .a(ap_mag_ff[g]), .b(ab_mag_ff[g]),
                                           .p(dot_p[g]));
      ssc_mul #(.AW(DW), .BW(DW)) u_cr_a  (.clock, .a(ap_mag_ff[(g+1)%3]),
                                           .b(ab_mag_ff[(g+2)%3]), .p(cr[2*g]));
      ssc_mul #(.AW(DW), .BW(DW)) u_cr_b  (.clock, .a(ap_mag_ff[(g+2)%3]),
                                           .b(ab_mag_ff[(g+1)%3]), .p(cr[2*g+1]));
      ssc_mul #(.AW(CW), .BW(CW)) u_sq_c  (.clock, .a(cm_ff[g]), .b(cm_ff[g]),
                                           .p(sq_c[g]));
   end

   ssc_mul #(.AW(W), .BW(W)) u_r2 (.clock, .a(rsum_ff), .b(rsum_ff), .p(r2));
   ssc_mul #(.AW(RW), .BW(SW)) u_rl (.clock, .a(r2d_ff), .b(len2_ff), .p(rl));

   always_comb begin
      logic s1, s2;
      len2_in = SW'(sq_ab[0]) + SW'(sq_ab[1]) + SW'(sq_ab[2]);
      dap_in  = SW'(sq_ap[0]) + SW'(sq_ap[1]) + SW'(sq_ap[2]);
      dbp_in  = SW'(sq_bp[0]) + SW'(sq_bp[1]) + SW'(sq_bp[2]);
      pos_in  = '0;
      negs_in = '0;
      for (int i = 0; i < 3; i++) begin
         if (ap_neg3_ff[i] ^ ab_neg3_ff[i]) begin
            negs_in = negs_in + SW'(dot_p[i]);
         end else begin
            pos_in = pos_in + SW'(dot_p[i]);
         end
      end
      for (int k = 0; k < 3; k++) begin
         s1 = ap_neg3_ff[(k+1)%3] ^ ab_neg3_ff[(k+2)%3];
         s2 = ap_neg3_ff[(k+2)%3] ^ ab_neg3_ff[(k+1)%3];
         if (s1 != s2) begin
            cm_in[k] = CW'(cr[2*k]) + CW'(cr[2*k+1]);
         end else if (cr[2*k] >= cr[2*k+1]) begin
            cm_in[k] = CW'(cr[2*k] - cr[2*k+1]);
         end else begin
            cm_in[k] = CW'(cr[2*k+1] - cr[2*k]);
         end
      end
   end

   always_ff @(posedge clock) begin
      len2_ff <= len2_in;
      pos_ff  <= pos_in;
      negs_ff <= negs_in;
      dap_ff  <= dap_in;
      dbp_ff  <= dbp_in;
      cm_ff   <= cm_in;
      r2d_ff  <= r2;
   end

   always_ff @(posedge clock) begin
      flg5_ff <= {pos_ff <= negs_ff,
                  (SW+1)'(pos_ff) >= (SW+1)'(negs_ff) + (SW+1)'(len2_ff),
                  dap_ff <= SW'(r2d_ff),
                  dbp_ff <= SW'(r2d_ff)};
      flg6_ff <= flg5_ff;
      flg7_ff <= flg6_ff;
      csum_ff <= QW'(sq_c[0]) + QW'(sq_c[1]) + QW'(sq_c[2]);
      rl7_ff  <= rl;
      hit_ff  <= hit_in;
   end

   always_comb begin
      if (flg7_ff[3]) begin
         hit_in = flg7_ff[1];
      end else if (flg7_ff[2]) begin
         hit_in = flg7_ff[0];
      end else begin
         hit_in = (QW + LW)'(csum_ff) <= (QW + LW)'(rl7_ff);
      end
   end

   assign rsp_valid = vld_ff[PIPE_DEPTH-1];
   assign rsp_hit   = hit_ff;
endmodule

// File: src/ssc_checker.sv
// Port-level checker for the swept sphere collision unit, with its bind
`timescale 1ns / 1ps
`include "swept_sphere_collision_unit_defines.svh"
module ssc_checker
   import ssc_pkg::*;
#(
   parameter int COORD_WIDTH = COORD_WIDTH_DEF
) (
   input logic                   clock,
   input logic                   reset,
   input logic                   start,
   input logic                   busy,
   input logic [COORD_WIDTH-1:0] req_prev_x,
   input logic [COORD_WIDTH-1:0] req_prev_y,
   input logic [COORD_WIDTH-1:0] req_prev_z,
   input logic [COORD_WIDTH-1:0] req_target_x,
   input logic [COORD_WIDTH-1:0] req_target_y,
   input logic [COORD_WIDTH-1:0] req_target_z,
   input logic                   rsp_valid,
   input logic                   rsp_hit
);
   `SSC_ASSERT_LATER(a_resp_follows, start && !busy, 8, rsp_valid)
   `SSC_ASSERT_LATER(a_no_spurious, !(start && !busy), 8, !rsp_valid)
   `SSC_ASSERT_LATER(a_start_inside, start && !busy && req_prev_x == req_target_x && req_prev_y == req_target_y && req_prev_z == req_target_z, 8, rsp_hit)
endmodule

bind swept_sphere_collision_unit ssc_checker #(.COORD_WIDTH(COORD_WIDTH)) u_ssc_checker (.*);
